>>> rtl/tagged_slot_allocator_assert.svh
// Assertion macros used by the slot allocator datapath.
`ifndef TAGGED_SLOT_ALLOCATOR_ASSERT_SVH
`define TAGGED_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Check that an antecedent implies its consequent on every clock edge out of reset.
`define TSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds out of reset.
`define TSA_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TSA_ASSERT(label, clk, rst, prop, msg)
`define TSA_NEVER(label, clk, rst, cond, msg)
`endif

`endif

>>> rtl/tsa_pkg.sv
// Shared constants, codes and types of the slot allocator.
package tsa_pkg;

   localparam int SLOTS  = 64;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int SIU_W  = 7;
   localparam int ID_W   = 64;
   localparam int DATA_W = 32;
   localparam int OFF_W  = 44;
   localparam int PROD_W = DATA_W + IDX_W;
   localparam int ADDR_W = 5;
   localparam int REG_W  = 3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic CMD_STORE   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [REG_W-1:0] REG_SLOTS   = 3'd0;
   localparam logic [REG_W-1:0] REG_MAX     = 3'd1;
   localparam logic [REG_W-1:0] REG_FIXED   = 3'd2;
   localparam logic [REG_W-1:0] REG_BASE    = 3'd3;
   localparam logic [REG_W-1:0] REG_PITCH   = 3'd4;

   localparam logic [ID_W-1:0] ID_FIRST = 64'd1;

   typedef struct packed {
      logic [SIU_W-1:0]  slots_in_use;
      logic [DATA_W-1:0] max_payload;
      logic              fixed_mode;
      logic [DATA_W-1:0] payload_base;
      logic [DATA_W-1:0] slot_pitch;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic pick;
      logic commit;
      logic finish;
   } ctrl_cmd_type;

endpackage

>>> rtl/tsa_csr.sv
// APB register file holding the pool configuration.
module tsa_csr
   import tsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg,
   output logic              pool_clear
);

   cfg_type          cfg_ff, cfg_in;
   logic             wr_en;
   logic [REG_W-1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[ADDR_W-1:2];

   always_comb begin
      cfg_in     = cfg_ff;
      pool_clear = 1'b0;
      if (wr_en) begin
         pool_clear = 1'b1;
         case (reg_sel)
            REG_SLOTS: cfg_in.slots_in_use = pwdata[SIU_W-1:0];
            REG_MAX:   cfg_in.max_payload  = pwdata;
            REG_FIXED: cfg_in.fixed_mode   = pwdata[0];
            REG_BASE:  cfg_in.payload_base = pwdata;
            REG_PITCH: cfg_in.slot_pitch   = pwdata;
            default:   pool_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{slots_in_use: '0, max_payload: '0, fixed_mode: 1'b1,
                     payload_base: '0, slot_pitch: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SLOTS: prdata = DATA_W'(cfg_ff.slots_in_use);
         REG_MAX:   prdata = cfg_ff.max_payload;
         REG_FIXED: prdata = DATA_W'(cfg_ff.fixed_mode);
         REG_BASE:  prdata = cfg_ff.payload_base;
         REG_PITCH: prdata = cfg_ff.slot_pitch;
         default:   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/tsa_ctrl.sv
// Sequencer that steps one request through scan, pick, commit and finish.
module tsa_ctrl
   import tsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_PICK   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      case (state_ff)
         S_IDLE:   state_in = start ? S_SCAN : S_IDLE;
         S_SCAN:   state_in = S_PICK;
         S_PICK:   state_in = S_COMMIT;
         S_COMMIT: state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign cmd.capture = start & (state_ff == S_IDLE);
   assign cmd.scan    = (state_ff == S_SCAN);
   assign cmd.pick    = (state_ff == S_PICK);
   assign cmd.commit  = (state_ff == S_COMMIT);
   assign cmd.finish  = (state_ff == S_FINISH);

endmodule

>>> rtl/tsa_dp.sv
// Slot flags, loan tags, id counter and the result path.
`include "tagged_slot_allocator_assert.svh"

module tsa_dp
   import tsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   input  cfg_type           cfg,
   input  logic              pool_clear,
   input  logic              req_cmd,
   input  logic [DATA_W-1:0] req_payload_bytes,
   input  logic [ID_W-1:0]   req_release_id,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_granted_id,
   output logic [IDX_W-1:0]  rsp_slot_number,
   output logic [OFF_W-1:0]  rsp_slot_offset
);

   logic                req_cmd_ff;
   logic [DATA_W-1:0]   req_bytes_ff;
   logic [ID_W-1:0]     req_id_ff;

   logic [SLOTS-1:0]    busy_ff, busy_in;
   logic [ID_W-1:0]     tag_ff [SLOTS];
   logic [ID_W-1:0]     cnt_ff, cnt_in;
   logic [ID_W-1:0]     draw_id;

   logic [SLOTS-1:0]    pool_mask;
   logic [SLOTS-1:0]    scan_vec;
   logic                scan_bad;
   logic [SLOTS-1:0]    vec_ff;
   logic                bad_ff;

   logic [IDX_W-1:0]    pick_idx;
   logic                pick_hit;
   logic [IDX_W-1:0]    idx_ff;
   logic [1:0]          status_ff;

   logic [ID_W-1:0]     grant_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                grant_ok;

   logic                rsp_strobe_ff;
   logic [1:0]          rsp_status_ff;
   logic [ID_W-1:0]     rsp_granted_id_ff;
   logic [IDX_W-1:0]    rsp_slot_number_ff;
   logic [OFF_W-1:0]    rsp_slot_offset_ff;

   // Hold the request.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff   <= req_cmd;
         req_bytes_ff <= req_payload_bytes;
         req_id_ff    <= req_release_id;
      end
   end

   // Per-slot compare: a free slot inside the pool, or a busy slot carrying the id.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         pool_mask[i] = (SIU_W'(i) < cfg.slots_in_use);
         if (req_cmd_ff == CMD_RELEASE) begin
            scan_vec[i] = busy_ff[i] & (tag_ff[i] == req_id_ff);
         end else begin
            scan_vec[i] = ~busy_ff[i] & pool_mask[i];
         end
      end
      if (req_cmd_ff == CMD_RELEASE) begin
         scan_bad = (req_id_ff == '0);
      end else begin
         scan_bad = (cfg.slots_in_use == '0) || (req_bytes_ff > cfg.max_payload) ||
                    (cfg.fixed_mode && (req_bytes_ff == '0));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         vec_ff <= scan_vec;
         bad_ff <= scan_bad;
      end
   end

   // Lowest set bit wins.
   always_comb begin
      pick_idx = '0;
      pick_hit = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec_ff[i]) begin
            pick_idx = IDX_W'(i);
            pick_hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         idx_ff <= pick_idx;
         if (bad_ff) begin
            status_ff <= ST_INVALID;
         end else if (pick_hit) begin
            status_ff <= ST_OK;
         end else begin
            status_ff <= (req_cmd_ff == CMD_RELEASE) ? ST_NOT_FOUND : ST_FULL;
         end
      end
   end

   // Skip zero when the counter has wrapped.
   assign draw_id  = (cnt_ff == '0) ? ID_FIRST : cnt_ff;
   assign grant_ok = (status_ff == ST_OK) && (req_cmd_ff == CMD_STORE);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (pool_clear) begin
         busy_in = '0;
         cnt_in  = ID_FIRST;
      end else if (cmd.commit && (status_ff == ST_OK)) begin
         busy_in[idx_ff] = (req_cmd_ff == CMD_STORE);
         if (req_cmd_ff == CMD_STORE) begin
            cnt_in = draw_id + ID_FIRST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         cnt_ff  <= ID_FIRST;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && grant_ok) begin
         tag_ff[idx_ff] <= draw_id;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         grant_ff <= draw_id;
         prod_ff  <= PROD_W'(cfg.slot_pitch) * PROD_W'(idx_ff);
      end
   end

   // Drive zero fields on anything but a granted store.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         if (grant_ok) begin
            rsp_granted_id_ff  <= grant_ff;
            rsp_slot_number_ff <= idx_ff;
            rsp_slot_offset_ff <= OFF_W'(cfg.payload_base) + OFF_W'(prod_ff);
         end else begin
            rsp_granted_id_ff  <= '0;
            rsp_slot_number_ff <= '0;
            rsp_slot_offset_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_granted_id  = rsp_granted_id_ff;
   assign rsp_slot_number = rsp_slot_number_ff;
   assign rsp_slot_offset = rsp_slot_offset_ff;

   `TSA_NEVER(a_busy_in_pool, clock, reset, |(busy_ff & ~pool_mask), "busy slot outside pool")
   `TSA_ASSERT(a_grant_nonzero, clock, reset, cmd.finish && grant_ok |=> rsp_granted_id_ff != '0, "zero id granted")
   `TSA_ASSERT(a_store_sets, clock, reset, cmd.commit && grant_ok && !pool_clear |=> busy_ff[idx_ff], "claimed slot not marked")
   `TSA_ASSERT(a_release_frees, clock, reset, cmd.commit && (status_ff == ST_OK) && (req_cmd_ff == CMD_RELEASE) |=> !busy_ff[idx_ff], "released slot still busy")

endmodule

>>> rtl/tagged_slot_allocator.sv
// Top level of the first-fit slot allocator with 64-bit loan ids.
//
//   Channel   Handshake                      Payload
//   request   start / busy                   req_cmd, req_payload_bytes, req_release_id
//   result    rsp_strobe (one cycle)         rsp_status, rsp_granted_id, rsp_slot_number,
//                                            rsp_slot_offset
//   config    psel / penable / pwrite        paddr, pwdata, prdata (pready tied high)
//
// A request is taken when start is high and busy is low. It then walks these steps:
// scan (all 64 tag compares and free checks in parallel), pick (priority encode of the
// lowest hit), commit (flag, tag and counter update, offset multiply), finish (offset add,
// result registered), and the result strobe cycle, in which busy is already low.
// Busy stays high from scan through finish, so no new request is taken before then.
// Reset is synchronous and clears all slots, sets the id counter to one and loads the
// register defaults. Any write to a listed register clears the pool the same way.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tagged_slot_allocator
   import tsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [DATA_W-1:0] req_payload_bytes,
   input  logic [ID_W-1:0]   req_release_id,

   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_granted_id,
   output logic [IDX_W-1:0]  rsp_slot_number,
   output logic [OFF_W-1:0]  rsp_slot_offset,

   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type      cfg;
   logic         pool_clear;
   ctrl_cmd_type cmd;

   // Register file: a write to any listed register also drops every loan.
   tsa_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .pool_clear (pool_clear)
   );

   // Sequencer: advance one request through its fixed steps.
   tsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Datapath: slot flags, tags, id counter and the registered result.
   tsa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .pool_clear        (pool_clear),
      .req_cmd           (req_cmd),
      .req_payload_bytes (req_payload_bytes),
      .req_release_id    (req_release_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_granted_id    (rsp_granted_id),
      .rsp_slot_number   (rsp_slot_number),
      .rsp_slot_offset   (rsp_slot_offset)
   );

endmodule
